/* rtl/qte_pkg.sv */
// Types and constants shared by the quaternion to Euler angle unit.
`timescale 1ns / 1ps

package qte_pkg;

  localparam int CompBits      = 16;
  localparam int AngleFracBits = 12;
  localparam int AngleBits     = 16;
  localparam int OpW           = 36;  // atan2 operand width
  localparam int ZW            = 34;  // Q2.30 angle with room for the +-pi offset
  localparam int CordicSteps   = 31;
  localparam int Lanes         = 3;

  localparam int LaneRoll  = 0;
  localparam int LanePitch = 1;
  localparam int LaneYaw   = 2;

  localparam logic signed [ZW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;

  localparam logic [29:0] AtanQ30 [CordicSteps] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1
  };

  typedef logic signed [OpW-1:0] opnd_t;
  typedef logic signed [ZW-1:0]  angle_t;

  typedef struct packed {
    logic signed [CompBits-1:0] quat_x;
    logic signed [CompBits-1:0] quat_y;
    logic signed [CompBits-1:0] quat_z;
    logic signed [CompBits-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [AngleBits-1:0] roll_angle;
    logic signed [AngleBits-1:0] pitch_angle;
    logic signed [AngleBits-1:0] yaw_angle;
    logic                        zero_input;
    logic                        pitch_clamped;
  } euler_t;

  typedef struct packed {
    logic zero_input;
    logic pitch_clamped;
  } tag_t;

  typedef struct packed {
    opnd_t       roll_a;
    opnd_t       roll_b;
    opnd_t       yaw_a;
    opnd_t       yaw_b;
    logic        neg;
    logic [30:0] us;
    tag_t        tag;
  } side_t;

endpackage

/* rtl/quaternion_to_euler_angles_unit.sv */
// Throughput: one item per cycle; a stall at the output holds every stage.
// Depth is set by the 31-stage square root feeding the 31-stage CORDIC.
// Reset clears all valid bits and the inverse mode register.
// Top level: quaternion to roll, pitch and yaw converter.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qte_pkg::quat_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qte_pkg::euler_t  out_data_o
);

  localparam int CB    = qte_pkg::CompBits;
  localparam int OpW   = qte_pkg::OpW;
  localparam int CW2   = 17;
  localparam int PrW   = 32;
  localparam int IsqW  = 64;
  localparam int Steps = qte_pkg::CordicSteps;
  localparam int KMax  = (CB > 16) ? CB - 16 : 0;
  localparam int Sh    = 30 - qte_pkg::AngleFracBits;
  localparam int RW    = qte_pkg::ZW + 1;
  localparam int NumProd = 10;
  localparam int PXX = 0, PYY = 1, PZZ = 2, PWW = 3, PWX = 4;
  localparam int PYZ = 5, PWZ = 6, PXY = 7, PWY = 8, PZX = 9;

  logic en;
  logic inv_mode_q;
  logic out_valid_q;
  qte_pkg::euler_t out_data_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      inv_mode_q <= cfg_data_i;
    end
  end

  // stage 1: sign extend, optional w negate
  logic              v1_q;
  logic signed [CB:0] c1_q [4];

  // stage 2: scale down wide components
  logic              v2_q, zero2_q;
  logic [CB:0]       mag2 [4];
  logic [CB:0]       m2;
  logic [4:0]        k2;
  logic signed [CW2-1:0] c2_d [4], c2_q [4];

  // stage 3: products
  logic              v3_q, zero3_q;
  logic signed [PrW-1:0] p3_q [NumProd];

  // stage 4: sums and clamp
  logic              v4_q;
  qte_pkg::tag_t     tag4_q;
  qte_pkg::opnd_t    n4_d, s4_d, n4_q, s4_q;
  qte_pkg::opnd_t    ra4_q, rb4_q, ya4_q, yb4_q;
  logic              clamp4_d;

  // stage 5: normalize n into [2^30, 2^31)
  logic              v5_q;
  qte_pkg::side_t    side5_q;
  logic [30:0]       un5_q;
  logic [32:0]       un4;
  logic [33:0]       us4;
  logic [5:0]        p4;
  logic [IsqW-1:0]   un_sh, us_sh;

  // stage 6 and 7: squares and difference
  logic              v6_q;
  qte_pkg::side_t    side6_q;
  logic [61:0]       uu6_q, vv6_q;

  // square root stages
  logic              sv_q [Steps+1];
  qte_pkg::side_t    sside_q [Steps+1];
  logic [IsqW-1:0]   sd_q [Steps+1];
  logic [IsqW-1:0]   sr_q [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      for (int j = 0; j <= Steps; j++) sv_q[j] <= 1'b0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      sv_q[0]  <= v6_q;
      for (int j = 0; j < Steps; j++) sv_q[j+1] <= sv_q[j];
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q[0] <= (CB+1)'(in_data_i.quat_x);
      c1_q[1] <= (CB+1)'(in_data_i.quat_y);
      c1_q[2] <= (CB+1)'(in_data_i.quat_z);
      c1_q[3] <= inv_mode_q ? -(CB+1)'(in_data_i.quat_w) : (CB+1)'(in_data_i.quat_w);
    end
  end

  // stage 2: shift all magnitudes together until the largest fits 32768
  always_comb begin
    m2 = '0;
    for (int i = 0; i < 4; i++) begin
      mag2[i] = (c1_q[i] < 0) ? (CB+1)'(-c1_q[i]) : (CB+1)'(c1_q[i]);
      if (mag2[i] > m2) m2 = mag2[i];
    end
    k2 = '0;
    for (int kk = KMax; kk >= 0; kk--) begin
      if ((m2 >> kk) <= (CB+1)'(32768)) k2 = 5'(kk);
    end
    for (int i = 0; i < 4; i++) begin
      c2_d[i] = (c1_q[i] < 0) ? -$signed({1'b0, 16'(mag2[i] >> k2)})
                              :  $signed({1'b0, 16'(mag2[i] >> k2)});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q    <= c2_d;
      zero2_q <= (m2 == '0);
    end
  end

  // stage 3: x y z w = c2_q[0..3]
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero3_q  <= zero2_q;
      p3_q[PXX] <= PrW'(c2_q[0]) * PrW'(c2_q[0]);
      p3_q[PYY] <= PrW'(c2_q[1]) * PrW'(c2_q[1]);
      p3_q[PZZ] <= PrW'(c2_q[2]) * PrW'(c2_q[2]);
      p3_q[PWW] <= PrW'(c2_q[3]) * PrW'(c2_q[3]);
      p3_q[PWX] <= PrW'(c2_q[3]) * PrW'(c2_q[0]);
      p3_q[PYZ] <= PrW'(c2_q[1]) * PrW'(c2_q[2]);
      p3_q[PWZ] <= PrW'(c2_q[3]) * PrW'(c2_q[2]);
      p3_q[PXY] <= PrW'(c2_q[0]) * PrW'(c2_q[1]);
      p3_q[PWY] <= PrW'(c2_q[3]) * PrW'(c2_q[1]);
      p3_q[PZX] <= PrW'(c2_q[2]) * PrW'(c2_q[0]);
    end
  end

  // stage 4
  always_comb begin
    n4_d = OpW'(p3_q[PXX]) + OpW'(p3_q[PYY]) + OpW'(p3_q[PZZ]) + OpW'(p3_q[PWW]);
    s4_d = (OpW'(p3_q[PWY]) - OpW'(p3_q[PZX])) <<< 1;
    clamp4_d = 1'b0;
    if (s4_d > n4_d) begin
      s4_d     = n4_d;
      clamp4_d = 1'b1;
    end else if (s4_d < -n4_d) begin
      s4_d     = -n4_d;
      clamp4_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q   <= n4_d;
      s4_q   <= s4_d;
      ra4_q  <= (OpW'(p3_q[PWX]) + OpW'(p3_q[PYZ])) <<< 1;
      rb4_q  <= n4_d - ((OpW'(p3_q[PXX]) + OpW'(p3_q[PYY])) <<< 1);
      ya4_q  <= (OpW'(p3_q[PWZ]) + OpW'(p3_q[PXY])) <<< 1;
      yb4_q  <= n4_d - ((OpW'(p3_q[PYY]) + OpW'(p3_q[PZZ])) <<< 1);
      tag4_q <= '{zero_input: zero3_q, pitch_clamped: clamp4_d};
    end
  end

  // stage 5
  always_comb begin
    un4 = n4_q[32:0];
    us4 = (s4_q < 0) ? 34'(-s4_q) : 34'(s4_q);
    p4  = '0;
    for (int b = 0; b < 33; b++) begin
      if (un4[b]) p4 = 6'(b);
    end
    if (p4 > 6'd30) begin
      un_sh = IsqW'(un4) >> (p4 - 6'd30);
      us_sh = IsqW'(us4) >> (p4 - 6'd30);
    end else begin
      un_sh = IsqW'(un4) << (6'd30 - p4);
      us_sh = IsqW'(us4) << (6'd30 - p4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      un5_q          <= un_sh[30:0];
      side5_q.roll_a <= ra4_q;
      side5_q.roll_b <= rb4_q;
      side5_q.yaw_a  <= ya4_q;
      side5_q.yaw_b  <= yb4_q;
      side5_q.neg    <= (s4_q < 0);
      side5_q.us     <= us_sh[30:0];
      side5_q.tag    <= tag4_q;
    end
  end

  // stages 6 and 7
  always_ff @(posedge clk_i) begin
    if (en) begin
      uu6_q      <= 62'(un5_q) * 62'(un5_q);
      vv6_q      <= 62'(side5_q.us) * 62'(side5_q.us);
      side6_q    <= side5_q;
      sd_q[0]    <= IsqW'(uu6_q - vv6_q);
      sr_q[0]    <= '0;
      sside_q[0] <= side6_q;
    end
  end

  // one result bit per stage; the radicand stays below 2^62, so the
  // square root starts at the 2^60 trial bit
  for (genvar j = 0; j < Steps; j++) begin : g_isqrt
    localparam logic [IsqW-1:0] Bit = IsqW'(1) << (60 - 2 * j);
    logic [IsqW-1:0] trial;
    assign trial = sr_q[j] + Bit;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sd_q[j] >= trial) begin
          sd_q[j+1] <= sd_q[j] - trial;
          sr_q[j+1] <= (sr_q[j] >> 1) + Bit;
        end else begin
          sd_q[j+1] <= sd_q[j];
          sr_q[j+1] <= sr_q[j] >> 1;
        end
        sside_q[j+1] <= sside_q[j];
      end
    end
  end

  qte_pkg::opnd_t  cin_a [qte_pkg::Lanes];
  qte_pkg::opnd_t  cin_b [qte_pkg::Lanes];
  qte_pkg::opnd_t  us_ext;
  qte_pkg::angle_t ang [qte_pkg::Lanes];
  qte_pkg::tag_t   ctag;
  logic            cvalid;

  assign us_ext = $signed({{(OpW-31){1'b0}}, sside_q[Steps].us});
  assign cin_a[qte_pkg::LaneRoll]  = sside_q[Steps].roll_a;
  assign cin_b[qte_pkg::LaneRoll]  = sside_q[Steps].roll_b;
  assign cin_a[qte_pkg::LanePitch] = sside_q[Steps].neg ? -us_ext : us_ext;
  assign cin_b[qte_pkg::LanePitch] = $signed(sr_q[Steps][OpW-1:0]);
  assign cin_a[qte_pkg::LaneYaw]   = sside_q[Steps].yaw_a;
  assign cin_b[qte_pkg::LaneYaw]   = sside_q[Steps].yaw_b;

  qte_atan2 u_atan2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_q[Steps]),
    .tag_i   (sside_q[Steps].tag),
    .a_i     (cin_a),
    .b_i     (cin_b),
    .valid_o (cvalid),
    .tag_o   (ctag),
    .angle_o (ang)
  );

  // round half up to the output scale and saturate; a zero input forces zero
  logic signed [RW-1:0]        rnd [qte_pkg::Lanes];
  logic signed [qte_pkg::AngleBits-1:0] sat [qte_pkg::Lanes];

  always_comb begin
    for (int l = 0; l < qte_pkg::Lanes; l++) begin
      rnd[l] = (RW'(ang[l]) + (RW'(1) <<< (Sh - 1))) >>> Sh;
      if (rnd[l] > RW'(32767)) begin
        sat[l] = 16'sd32767;
      end else if (rnd[l] < -RW'(32768)) begin
        sat[l] = -16'sd32768;
      end else begin
        sat[l] = rnd[l][qte_pkg::AngleBits-1:0];
      end
      if (ctag.zero_input) sat[l] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.roll_angle    <= sat[qte_pkg::LaneRoll];
      out_data_q.pitch_angle   <= sat[qte_pkg::LanePitch];
      out_data_q.yaw_angle     <= sat[qte_pkg::LaneYaw];
      out_data_q.zero_input    <= ctag.zero_input;
      out_data_q.pitch_clamped <= ctag.pitch_clamped && !ctag.zero_input;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/qte_atan2.sv */
// Three-lane pipelined CORDIC atan2 in vectoring mode, Q2.30 result.
`timescale 1ns / 1ps

module qte_atan2 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  qte_pkg::tag_t       tag_i,
  input  qte_pkg::opnd_t      a_i [qte_pkg::Lanes],
  input  qte_pkg::opnd_t      b_i [qte_pkg::Lanes],
  output logic                valid_o,
  output qte_pkg::tag_t       tag_o,
  output qte_pkg::angle_t     angle_o [qte_pkg::Lanes]
);

  localparam int Steps = qte_pkg::CordicSteps;
  localparam int XW    = qte_pkg::OpW + 1;
  localparam int CW    = 45;
  localparam int NormMsb = 40;

  // valid and tag chain: prep, normalize, Steps iterations, then output
  logic          vld0_q, vld_q [Steps+1], vout_q;
  qte_pkg::tag_t tag0_q, tag_q [Steps+1], tout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vout_q <= 1'b0;
      for (int i = 0; i <= Steps; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld0_q   <= valid_i;
      vld_q[0] <= vld0_q;
      for (int i = 0; i < Steps; i++) vld_q[i+1] <= vld_q[i];
      vout_q   <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag0_q   <= tag_i;
      tag_q[0] <= tag0_q;
      for (int i = 0; i < Steps; i++) tag_q[i+1] <= tag_q[i];
      tout_q   <= tag_q[Steps];
    end
  end

  assign valid_o = vout_q;
  assign tag_o   = tout_q;

  for (genvar l = 0; l < qte_pkg::Lanes; l++) begin : g_lane
    logic signed [XW-1:0] x_d, y_d, ya_d, m_d;
    logic signed [XW-1:0] x0_q, y0_q, m0_q;
    logic                 spec_d, spec0_q;
    qte_pkg::angle_t      base_d, base0_q;
    logic [5:0]           sh_d;

    logic signed [CW-1:0] it_x_q [Steps+1];
    logic signed [CW-1:0] it_y_q [Steps+1];
    qte_pkg::angle_t      it_z_q [Steps+1];
    qte_pkg::angle_t      it_base_q [Steps+1];
    logic                 it_spec_q [Steps+1];
    qte_pkg::angle_t      ang_q;

    // fold into the right half plane, pick out the axis cases
    always_comb begin
      spec_d = (a_i[l] == '0) || (b_i[l] == '0);
      if (b_i[l] < 0) begin
        x_d    = -XW'(b_i[l]);
        y_d    = -XW'(a_i[l]);
        base_d = (a_i[l] > 0) ? qte_pkg::PiQ30 : -qte_pkg::PiQ30;
      end else begin
        x_d    = XW'(b_i[l]);
        y_d    = XW'(a_i[l]);
        base_d = '0;
      end
      if (a_i[l] == '0) begin
        base_d = (b_i[l] < 0) ? qte_pkg::PiQ30 : '0;
      end else if (b_i[l] == '0) begin
        base_d = (a_i[l] > 0) ? qte_pkg::HalfPiQ30 : -qte_pkg::HalfPiQ30;
      end
      ya_d = (y_d < 0) ? -y_d : y_d;
      m_d  = (x_d > ya_d) ? x_d : ya_d;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x0_q    <= x_d;
        y0_q    <= y_d;
        m0_q    <= m_d;
        spec0_q <= spec_d;
        base0_q <= base_d;
      end
    end

    // scale so the larger operand lands in [2^40, 2^41)
    always_comb begin
      sh_d = 6'(NormMsb);
      for (int b = 0; b < XW - 1; b++) begin
        if (m0_q[b]) sh_d = 6'(NormMsb - b);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_x_q[0]    <= CW'(x0_q) <<< sh_d;
        it_y_q[0]    <= CW'(y0_q) <<< sh_d;
        it_z_q[0]    <= '0;
        it_base_q[0] <= base0_q;
        it_spec_q[0] <= spec0_q;
      end
    end

    for (genvar i = 0; i < Steps; i++) begin : g_iter
      localparam qte_pkg::angle_t Atan = qte_pkg::angle_t'(qte_pkg::AtanQ30[i]);
      logic signed [CW-1:0] xs, ys;
      assign xs = it_x_q[i] >>> i;
      assign ys = it_y_q[i] >>> i;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (it_y_q[i] > 0) begin
            it_x_q[i+1] <= it_x_q[i] + ys;
            it_y_q[i+1] <= it_y_q[i] - xs;
            it_z_q[i+1] <= it_z_q[i] + Atan;
          end else begin
            it_x_q[i+1] <= it_x_q[i] - ys;
            it_y_q[i+1] <= it_y_q[i] + xs;
            it_z_q[i+1] <= it_z_q[i] - Atan;
          end
          it_base_q[i+1] <= it_base_q[i];
          it_spec_q[i+1] <= it_spec_q[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ang_q <= it_spec_q[Steps] ? it_base_q[Steps]
                                  : it_base_q[Steps] + it_z_q[Steps];
      end
    end

    assign angle_o[l] = ang_q;
  end

endmodule

/* rtl/qte_checker.sv */
// Port-level checks for the quaternion to Euler angle unit, with bind.
`timescale 1ns / 1ps

module qte_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input qte_pkg::euler_t out_data_o
);

  localparam int Sh = 30 - qte_pkg::AngleFracBits;
  localparam int PitchMax =
    int'((qte_pkg::HalfPiQ30 + (qte_pkg::angle_t'(1) <<< (Sh - 1))) >>> Sh) + 1;

  // zero quaternion gives clean zero angles
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_input |->
      out_data_o.roll_angle == '0 && out_data_o.pitch_angle == '0 &&
      out_data_o.yaw_angle == '0 && !out_data_o.pitch_clamped)
    else $error("zero item with nonzero angles");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(out_data_o.pitch_angle) <= PitchMax &&
                    $signed(out_data_o.pitch_angle) >= -PitchMax)
    else $error("pitch beyond half pi");

  // an empty output register never blocks the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item dropped or changed under stall");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
